[src/activation_function_unit_macros.svh]
// assertion macros shared by the activation function unit
`ifndef ACTIVATION_FUNCTION_UNIT_MACROS_SVH
`define ACTIVATION_FUNCTION_UNIT_MACROS_SVH

// same-cycle implication, checked on clk, off while rst_n is low
`define AFU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("afu check failed");

// next-cycle implication, checked on clk, off while rst_n is low
`define AFU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("afu check failed");

`endif

[src/afu_pkg.sv]
// types, fixed-point constants and rounding helpers of the activation function unit
package afu_pkg;

  typedef enum logic [2:0] {
    OP_GELU    = 3'd0,
    OP_ERF     = 3'd1,
    OP_TANH    = 3'd2,
    OP_SIGMOID = 3'd3,
    OP_MAX     = 3'd4
  } op_t;

  typedef struct packed {
    logic vld;
    op_t  op;
  } ctl_t;

  typedef struct packed {
    logic        neg;
    logic [31:0] bypass;
  } side_t;

  localparam int QBITS      = 31;
  localparam int IN_TDATA_W = 72;

  localparam longint GC1 = (64'd306923  * 64'd1073741824 + 64'd500000) / 64'd1000000;
  localparam longint GC2 = (64'd501000  * 64'd1073741824 + 64'd500000) / 64'd1000000;
  localparam longint GCM = (64'd1002000 * 64'd1073741824 + 64'd500000) / 64'd1000000;
  localparam longint GCK = (64'd997729  * 64'd1073741824 + 64'd500000) / 64'd1000000;
  localparam longint GCB = (64'd4004    * 64'd1073741824 + 64'd500000) / 64'd1000000;
  localparam longint EA3 = (64'd34298   * 64'd1073741824 + 64'd500000) / 64'd1000000;
  localparam longint EB0 = (64'd995000  * 64'd1073741824 + 64'd500000) / 64'd1000000;
  localparam longint EB2 = (64'd378089  * 64'd1073741824 + 64'd500000) / 64'd1000000;
  localparam longint EK  = (64'd1106774 * 64'd1073741824 + 64'd500000) / 64'd1000000;
  localparam longint TA3 = (64'd53639   * 64'd1073741824 + 64'd500000) / 64'd1000000;
  localparam longint TB0 = (64'd901220  * 64'd1073741824 + 64'd500000) / 64'd1000000;
  localparam longint TB2 = (64'd343141  * 64'd1073741824 + 64'd500000) / 64'd1000000;
  localparam longint TK  = (64'd900021  * 64'd1073741824 + 64'd500000) / 64'd1000000;
  localparam longint CB16     = (GCB + 64'd8192) >> 14;
  localparam longint HALF_Q30 = 64'd536870912;

  localparam logic signed [31:0] LIM2 = 32'sd131072;
  localparam logic signed [31:0] LIM3 = 32'sd196608;
  localparam logic signed [31:0] LIM6 = 32'sd393216;

  // round v / 2^s to nearest, ties away from zero
  function automatic logic signed [71:0] rnd(input logic signed [71:0] v,
                                             input int unsigned s);
    logic [71:0] m;
    logic [71:0] r;
    m = v[71] ? 72'(-v) : 72'(v);
    r = (m + (72'd1 << (s - 1))) >> s;
    return v[71] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [31:0] clampx(input logic signed [31:0] v,
                                                input logic signed [31:0] lim);
    logic signed [31:0] r;
    r = v;
    if (v > lim) r = lim;
    if (v < -lim) r = -lim;
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [71:0] v);
    logic [31:0] r;
    r = v[31:0];
    if (v > 72'sd2147483647) r = 32'h7fff_ffff;
    if (v < -72'sd2147483648) r = 32'h8000_0000;
    return r;
  endfunction

endpackage

[src/afu_poly.sv]
// front stages: operand clamps, polynomial terms, gelu and max paths, dividend setup
module afu_poly (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  afu_pkg::ctl_t           in_ctl,
  input  logic signed [31:0]      in_x,
  input  logic signed [31:0]      in_y,
  output afu_pkg::ctl_t           out_ctl,
  output logic [62:0]             out_n,
  output logic [31:0]             out_den,
  output afu_pkg::side_t          out_side
);

  afu_pkg::ctl_t c_r [7];

  logic signed [33:0] u1_r, u2s_r, u3s_r, u4_r, u5_r, u6_r;
  logic signed [31:0] x1_r, x2_r;
  logic [31:0]        mx1_r, mx2_r, mx3_r, mx4_r, mx5_r, mx6_r;
  logic signed [49:0] gp1_r;
  logic signed [67:0] u2p2_r;
  logic signed [31:0] gate2_r;
  logic signed [34:0] u23_r;
  logic signed [63:0] pp3_r;
  logic signed [69:0] u3p4_r;
  logic signed [66:0] bp4_r;
  logic signed [33:0] prod4_r;
  logic signed [36:0] u35_r;
  logic [31:0]        den5_r, den6_r;
  logic signed [65:0] gk5_r;
  logic signed [68:0] ap6_r;
  logic signed [33:0] gelu6_r;
  logic [62:0]        n7_r;
  logic [31:0]        den7_r;
  afu_pkg::side_t     side7_r;

  logic signed [31:0] xc, uc;
  logic signed [33:0] u_nxt;
  logic signed [71:0] g_full;
  logic signed [31:0] gate_nxt;
  logic signed [31:0] b2sel, b0sel, a3sel;
  logic signed [71:0] num_full;
  logic [32:0]        num_mag;
  logic [31:0]        byp_nxt;

  always_comb begin
    xc = afu_pkg::clampx(in_x, afu_pkg::LIM2);
    uc = '0;
    u_nxt = '0;
    case (in_ctl.op)
      afu_pkg::OP_ERF: begin
        uc = afu_pkg::clampx(in_x, afu_pkg::LIM2);
        u_nxt = {{2{uc[31]}}, uc} <<< 14;
      end
      afu_pkg::OP_TANH: begin
        uc = afu_pkg::clampx(in_x, afu_pkg::LIM3);
        u_nxt = {{2{uc[31]}}, uc} <<< 14;
      end
      afu_pkg::OP_SIGMOID: begin
        uc = afu_pkg::clampx(in_x, afu_pkg::LIM6);
        u_nxt = {{2{uc[31]}}, uc} <<< 13;
      end
      default: begin
        uc = '0;
        u_nxt = '0;
      end
    endcase
  end

  always_comb begin
    g_full = afu_pkg::rnd(72'(gp1_r), 16) + 72'(afu_pkg::GC2);
    gate_nxt = 32'(g_full);
    if (g_full < 72'sd0) gate_nxt = '0;
    if (g_full > 72'(afu_pkg::GCM)) gate_nxt = 32'(afu_pkg::GCM);
  end

  always_comb begin
    b2sel = (c_r[2].op == afu_pkg::OP_ERF) ? 32'(afu_pkg::EB2) : 32'(afu_pkg::TB2);
    b0sel = (c_r[3].op == afu_pkg::OP_ERF) ? 32'(afu_pkg::EB0) : 32'(afu_pkg::TB0);
    a3sel = (c_r[4].op == afu_pkg::OP_ERF) ? 32'(afu_pkg::EA3) : 32'(afu_pkg::TA3);
  end

  always_comb begin
    num_full = 72'(u6_r) + afu_pkg::rnd(72'(ap6_r), 30);
    num_mag  = num_full[71] ? 33'(-num_full) : 33'(num_full);
    case (c_r[5].op)
      afu_pkg::OP_GELU: byp_nxt = afu_pkg::sat32(72'(gelu6_r));
      afu_pkg::OP_MAX:  byp_nxt = mx6_r;
      default:          byp_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 7; i++) c_r[i] <= '0;
    end else if (en) begin
      c_r[0] <= in_ctl;
      for (int i = 1; i < 7; i++) c_r[i] <= c_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1_r    <= u_nxt;
      x1_r    <= in_x;
      mx1_r   <= (in_x > in_y) ? in_x : in_y;
      gp1_r   <= $signed(31'(afu_pkg::GC1)) * $signed(xc[18:0]);

      u2s_r   <= u1_r;
      x2_r    <= x1_r;
      mx2_r   <= mx1_r;
      u2p2_r  <= u1_r * u1_r;
      gate2_r <= gate_nxt;

      u3s_r   <= u2s_r;
      mx3_r   <= mx2_r;
      u23_r   <= 35'(afu_pkg::rnd(72'(u2p2_r), 30));
      pp3_r   <= x2_r * gate2_r;

      u4_r    <= u3s_r;
      mx4_r   <= mx3_r;
      u3p4_r  <= u23_r * u3s_r;
      bp4_r   <= b2sel * u23_r;
      prod4_r <= 34'(afu_pkg::rnd(72'(pp3_r), 30));

      u5_r    <= u4_r;
      mx5_r   <= mx4_r;
      u35_r   <= 37'(afu_pkg::rnd(72'(u3p4_r), 30));
      den5_r  <= 32'(72'(b0sel) + afu_pkg::rnd(72'(bp4_r), 30));
      gk5_r   <= $signed(32'(afu_pkg::GCK)) * prod4_r;

      u6_r    <= u5_r;
      mx6_r   <= mx5_r;
      den6_r  <= den5_r;
      ap6_r   <= a3sel * u35_r;
      gelu6_r <= 34'(afu_pkg::rnd(72'(gk5_r), 30) - 72'(afu_pkg::CB16));

      n7_r           <= ({30'd0, num_mag} << 30) + {32'd0, den6_r[31:1]};
      den7_r         <= den6_r;
      side7_r.neg    <= num_full[71];
      side7_r.bypass <= byp_nxt;
    end
  end

  assign out_ctl  = c_r[6];
  assign out_n    = n7_r;
  assign out_den  = den7_r;
  assign out_side = side7_r;

endmodule

[src/afu_div.sv]
// pipelined restoring divider, one quotient bit per stage
module afu_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  afu_pkg::ctl_t                 in_ctl,
  input  logic [62:0]                   in_n,
  input  logic [31:0]                   in_den,
  input  afu_pkg::side_t                in_side,
  output afu_pkg::ctl_t                 out_ctl,
  output logic [afu_pkg::QBITS-1:0]     out_q,
  output afu_pkg::side_t                out_side
);

  localparam int NB = afu_pkg::QBITS;

  afu_pkg::ctl_t  c_r    [NB];
  afu_pkg::side_t side_r [NB];
  logic [31:0]    rem_r  [NB];
  logic [31:0]    den_r  [NB];
  logic [NB-1:0]  nlo_r  [NB];
  logic [NB-1:0]  q_r    [NB];

  for (genvar i = 0; i < NB; i++) begin : g_stage
    afu_pkg::ctl_t  c_in;
    afu_pkg::side_t s_in;
    logic [31:0]    rem_in, den_in;
    logic [NB-1:0]  nlo_in, q_in;
    logic [32:0]    t;
    logic           ge;

    if (i == 0) begin : g_first
      assign c_in   = in_ctl;
      assign s_in   = in_side;
      assign rem_in = in_n[62:NB];
      assign den_in = in_den;
      assign nlo_in = in_n[NB-1:0];
      assign q_in   = '0;
    end else begin : g_next
      assign c_in   = c_r[i-1];
      assign s_in   = side_r[i-1];
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign nlo_in = nlo_r[i-1];
      assign q_in   = q_r[i-1];
    end

    assign t  = {rem_in, nlo_in[NB-1-i]};
    assign ge = (t >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_r[i] <= '0;
      end else if (en) begin
        c_r[i] <= c_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i] <= s_in;
        den_r[i]  <= den_in;
        nlo_r[i]  <= nlo_in;
        rem_r[i]  <= ge ? 32'(t - {1'b0, den_in}) : t[31:0];
        q_r[i]    <= q_in | (NB'(ge) << (NB-1-i));
      end
    end
  end

  assign out_ctl  = c_r[NB-1];
  assign out_q    = q_r[NB-1];
  assign out_side = side_r[NB-1];

endmodule

[src/afu_post.sv]
// back stages: output scale, sigmoid offset, rounding to q15.16 and result select
module afu_post (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  afu_pkg::ctl_t                 in_ctl,
  input  logic [afu_pkg::QBITS-1:0]     in_q,
  input  afu_pkg::side_t                in_side,
  output logic                          out_valid,
  output logic [31:0]                   out_result
);

  afu_pkg::ctl_t      c_r [3];
  logic signed [63:0] kp1_r;
  afu_pkg::side_t     s1_r, s2_r;
  logic signed [33:0] t2_r;
  logic [31:0]        res3_r;

  logic signed [31:0] ksel;
  logic signed [71:0] t_full, v_full, r_full;
  logic [31:0]        res_nxt;

  always_comb begin
    ksel   = (in_ctl.op == afu_pkg::OP_ERF) ? 32'(afu_pkg::EK) : 32'(afu_pkg::TK);
    t_full = afu_pkg::rnd(72'(kp1_r), 30);
    if (s1_r.neg) t_full = -t_full;
    if (c_r[1].op == afu_pkg::OP_SIGMOID) begin
      v_full = 72'(afu_pkg::HALF_Q30) + afu_pkg::rnd(72'(t2_r), 1);
    end else begin
      v_full = 72'(t2_r);
    end
    r_full = afu_pkg::rnd(v_full, 14);
    case (c_r[1].op)
      afu_pkg::OP_ERF, afu_pkg::OP_TANH, afu_pkg::OP_SIGMOID: res_nxt = afu_pkg::sat32(r_full);
      default: res_nxt = s2_r.bypass;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) c_r[i] <= '0;
    end else if (en) begin
      c_r[0] <= in_ctl;
      c_r[1] <= c_r[0];
      c_r[2] <= c_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kp1_r  <= ksel * $signed({1'b0, in_q});
      s1_r   <= in_side;
      t2_r   <= 34'(t_full);
      s2_r   <= s1_r;
      res3_r <= res_nxt;
    end
  end

  assign out_valid  = c_r[2].vld;
  assign out_result = res3_r;

endmodule

[src/activation_function_unit.sv]
// activation function unit top level: input skid stage and the three pipeline sections
// Streams one item per cycle while the output is not stalled: gelu, erf, tanh, sigmoid
// or max of two on signed q15.16 operands, one saturated q15.16 result per item, in order.
// Each item passes from input acceptance to the output register through 7 front stages
// for the polynomial terms and dividend setup (one multiplier level in all but the last),
// 31 divider stages that each resolve one quotient bit of the rational form, and
// 3 back stages for scaling and rounding. All stages advance together whenever the output
// register is empty or being taken; a one-item skid stage keeps in_tready high for one more
// item while a result waits. Unused select codes give a result of zero.
module activation_function_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // op[2:0], x_value[34:3], y_value[66:35], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // result[31:0]
);

`include "activation_function_unit_macros.svh"

  logic          pipe_en;
  logic          skid_v_r, skid_v_nxt;
  logic [66:0]   skid_d_r;
  logic [66:0]   f_data;
  afu_pkg::ctl_t f_ctl;

  afu_pkg::ctl_t  p_ctl, d_ctl;
  logic [62:0]    p_n;
  logic [31:0]    p_den;
  afu_pkg::side_t p_side, d_side;
  logic [afu_pkg::QBITS-1:0] d_q;

  assign pipe_en   = !out_tvalid || out_tready;
  assign in_tready = !skid_v_r;

  always_comb begin
    f_data     = skid_v_r ? skid_d_r : in_tdata[66:0];
    f_ctl.vld  = skid_v_r || in_tvalid;
    f_ctl.op   = afu_pkg::op_t'(f_data[2:0]);
    skid_v_nxt = skid_v_r;
    if (pipe_en) begin
      skid_v_nxt = 1'b0;
    end else if (in_tvalid && !skid_v_r) begin
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else begin
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!pipe_en && in_tvalid && !skid_v_r) begin
      skid_d_r <= in_tdata[66:0];
    end
  end

  afu_poly u_poly (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_ctl   (f_ctl),
    .in_x     ($signed(f_data[34:3])),
    .in_y     ($signed(f_data[66:35])),
    .out_ctl  (p_ctl),
    .out_n    (p_n),
    .out_den  (p_den),
    .out_side (p_side)
  );

  afu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_ctl   (p_ctl),
    .in_n     (p_n),
    .in_den   (p_den),
    .in_side  (p_side),
    .out_ctl  (d_ctl),
    .out_q    (d_q),
    .out_side (d_side)
  );

  afu_post u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (pipe_en),
    .in_ctl     (d_ctl),
    .in_q       (d_q),
    .in_side    (d_side),
    .out_valid  (out_tvalid),
    .out_result (out_tdata)
  );

  `AFU_ASSERT_NXT(a_skid_fill, in_tvalid && in_tready && !pipe_en, skid_v_r)
  `AFU_ASSERT_NXT(a_skid_drain, skid_v_r && pipe_en, !skid_v_r)
  `AFU_ASSERT_IMP(a_skid_cause, $rose(skid_v_r), !$past(pipe_en))

endmodule
